// File: rtl/fest_pkg.sv
// fest_pkg: types, constants and sequencer states for the fault event status table
// used by fest_store, fest_seq and fault_event_status_table; no dependencies
package fest_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   localparam logic        OP_REPORT      = 1'b0;
   localparam logic        OP_MERGE       = 1'b1;
   localparam logic [1:0]  STATUS_PASSED  = 2'd0;
   localparam logic [1:0]  STATUS_FAILED  = 2'd1;
   localparam logic [15:0] NULL_ID        = 16'd0;

   typedef struct packed {
      logic        op;
      logic [15:0] event_id;
      logic [1:0]  event_status;
      logic [15:0] stored_occurrence;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        found;
      logic [15:0] occurrence;
      logic        is_failed;
      logic        changed;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic [15:0] event_id;
      logic [15:0] occurrence;
      logic        failed;
      logic        changed;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         data;
   } store_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

// File: rtl/fest_store.sv
// fest_store: slot memory with one write port and one registered read port
// per-slot valid bits cleared by reset make unwritten slots read as free; uses fest_pkg
module fest_store
   import fest_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  store_wr_type      wr,
   input  logic [SLOT_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type        mem [SLOTS];
   entry_type        rd_data_ff;
   logic             rd_valid_ff;
   logic [SLOTS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         // a write to the address being read is never overlapped during a scan
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/fest_seq.sv
// fest_seq: scan sequencer with the shared id comparator and occurrence adder
// walks the slots one per cycle, then updates at most one slot and builds the result; uses fest_pkg
module fest_seq
   import fest_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_item,
   input  logic              module_ready,
   input  entry_type         rd_data,
   output logic [SLOT_W-1:0] rd_addr,
   output store_wr_type      wr,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_type           rsp_item
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   req_type           req_ff, req_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type         hit_entry_ff, hit_entry_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              id_match;
   logic              slot_free;
   logic [15:0]       add_a;
   logic [15:0]       add_b;
   logic [15:0]       sum;
   logic              status_ok;
   logic              new_failed;
   entry_type         upd_entry;

   // shared compare and add unit
   assign id_match  = (rd_data.event_id == req_ff.event_id);
   assign slot_free = (rd_data.event_id == NULL_ID);
   assign add_a     = hit_ff ? hit_entry_ff.occurrence : 16'd0;
   assign add_b     = (req_ff.op == OP_MERGE) ? req_ff.stored_occurrence : 16'd1;
   assign sum       = add_a + add_b;

   assign status_ok  = (req_ff.event_status == STATUS_PASSED) ||
                       (req_ff.event_status == STATUS_FAILED);
   assign new_failed = (req_ff.event_status == STATUS_FAILED);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      req_ff       <= req_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rd_addr      = '0;
      wr           = '0;
      upd_entry    = hit_entry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // data for slot idx_ff is on rd_data; fetch the next one
            rd_addr = (idx_ff == LAST_SLOT) ? '0 : SLOT_W'(idx_ff + 1'b1);
            if (!hit_ff && id_match) begin
               hit_in       = 1'b1;
               hit_idx_in   = idx_ff;
               hit_entry_in = rd_data;
            end
            if (!free_ff && slot_free) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = SLOT_W'(idx_ff + 1'b1);
            end
         end
         ST_UPDATE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (req_ff.event_id != NULL_ID) begin
               if (req_ff.op == OP_REPORT) begin
                  if (module_ready && status_ok) begin
                     if (hit_ff) begin
                        if (hit_entry_ff.failed != new_failed) begin
                           if (new_failed) begin
                              upd_entry.occurrence = sum;
                           end
                           upd_entry.failed  = new_failed;
                           upd_entry.changed = 1'b1;
                        end else begin
                           upd_entry.changed = 1'b0;
                        end
                        wr.en   = 1'b1;
                        wr.addr = hit_idx_ff;
                        rsp_in.accepted = 1'b1;
                        rsp_in.found    = 1'b1;
                     end else if (new_failed) begin
                        if (free_ff) begin
                           upd_entry.event_id   = req_ff.event_id;
                           upd_entry.occurrence = sum;
                           upd_entry.failed     = 1'b1;
                           upd_entry.changed    = 1'b1;
                           wr.en   = 1'b1;
                           wr.addr = free_idx_ff;
                           rsp_in.accepted = 1'b1;
                           rsp_in.found    = 1'b1;
                        end else begin
                           rsp_in.table_full = 1'b1;
                        end
                     end
                  end else begin
                     // ignored report still shows the slot as it stands
                     rsp_in.found = hit_ff;
                  end
               end else begin
                  if (hit_ff) begin
                     upd_entry.occurrence = sum;
                     wr.en   = 1'b1;
                     wr.addr = hit_idx_ff;
                     rsp_in.accepted = 1'b1;
                     rsp_in.found    = 1'b1;
                  end else if (free_ff) begin
                     upd_entry.event_id   = req_ff.event_id;
                     upd_entry.occurrence = sum;
                     upd_entry.failed     = 1'b0;
                     upd_entry.changed    = 1'b0;
                     wr.en   = 1'b1;
                     wr.addr = free_idx_ff;
                     rsp_in.accepted = 1'b1;
                     rsp_in.found    = 1'b1;
                  end else begin
                     rsp_in.table_full = 1'b1;
                  end
               end
            end
            wr.data = upd_entry;
            if (rsp_in.found) begin
               rsp_in.occurrence = upd_entry.occurrence;
               rsp_in.is_failed  = upd_entry.failed;
               rsp_in.changed    = upd_entry.changed;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_UPDATE))
      else $error("result beat without an update cycle");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_UPDATE))
      else $error("slot write outside the update cycle");

   a_accept_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.accepted) |-> (rsp_ff.found && !rsp_ff.table_full))
      else $error("accepted result without a slot");

   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full) |-> (!rsp_ff.found && rsp_ff.occurrence == 16'd0))
      else $error("table full result shows a slot");

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("scan did not start at slot zero");

endmodule

// File: rtl/fault_event_status_table.sv
// fault_event_status_table: top level with the ready register, slot store and sequencer
// depends on fest_pkg, fest_store and fest_seq
//
//   channel  ports                               beat taken when
//   request  start, busy, req_item               start && !busy
//   result   rsp_strobe, rsp_item                rsp_strobe (one cycle, no stall)
//   config   csr_valid, csr_ready, csr_data      csr_valid && csr_ready
//
// busy stays high from the accepting edge through the scan of every slot, which goes
// through the single read port of the slot memory, and then through the update state
// the result beat shows in the cycle after the update, when busy has already dropped,
// so requests held back to back are taken only then, none while one is in flight
// reset is synchronous; the slot valid bits clear at once, no clearing pass
// results cannot be held off; config is taken only while idle with start low
module fault_event_status_table
   import fest_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic              module_ready_ff, module_ready_in;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_data;
   store_wr_type      wr;
   logic              seq_busy;

   // a request beat and a config beat never land on the same edge
   assign csr_ready       = ~seq_busy & ~start;
   assign module_ready_in = (csr_valid && csr_ready) ? csr_data : module_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_ready_ff <= 1'b0;
      end else begin
         module_ready_ff <= module_ready_in;
      end
   end

   fest_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fest_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_item     (req_item),
      .module_ready (module_ready_ff),
      .rd_data      (rd_data),
      .rd_addr      (rd_addr),
      .wr           (wr),
      .busy         (seq_busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item)
   );

   assign busy = seq_busy;

endmodule

// File: tb/fault_event_status_table_tb.sv
// fault_event_status_table_tb: self-checking bench for the fault event status table
// drives request beats and ready writes, predicts each slot record and checks every result
// depends on fest_pkg and fault_event_status_table
module fault_event_status_table_tb;
   import fest_pkg::*;

   typedef struct packed {
      req_type item;
      rsp_type rec;
   } pending_type;

   // one directed beat: ready setting it runs under, the request, and a typed record if any
   typedef struct packed {
      logic    ready;
      req_type item;
      logic    typed;
      rsp_type rec;
   } plan_row_type;

   localparam rsp_type NO_RECORD = '0;
   localparam int      PLAN_ROWS = 28;
   localparam int      RUN_LIMIT = 20_000_000;

   localparam logic [15:0] STRAY_IDS [4] = '{16'h7FFF, 16'h0003, 16'hA5A5, 16'h5A5A};

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // not ready: reports ignored, merges still act
      '{1'b0, '{OP_REPORT, 16'h0001, STATUS_FAILED, 16'h0000}, 1'b1,
         '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '{OP_MERGE, NULL_ID, STATUS_PASSED, 16'hFFFF}, 1'b1,
         '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0}},
      '{1'b0, '{OP_MERGE, 16'hFFFF, STATUS_PASSED, 16'hFFFF}, 1'b1,
         '{1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0}},
      // ready: count wraps on the change to failed
      '{1'b1, '{OP_REPORT, 16'hFFFF, STATUS_FAILED, 16'h0000}, 1'b1,
         '{1'b1, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0}},
      '{1'b1, '{OP_REPORT, 16'hFFFF, STATUS_FAILED, 16'hFFFF}, 1'b1,
         '{1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0}},
      '{1'b1, '{OP_REPORT, 16'hFFFF, STATUS_PASSED, 16'h0000}, 1'b1,
         '{1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b0}},
      '{1'b1, '{OP_REPORT, 16'h0002, STATUS_PASSED, 16'h0000}, 1'b1,
         '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0}},
      '{1'b1, '{OP_REPORT, 16'h0002, STATUS_FAILED, 16'h0000}, 1'b1,
         '{1'b1, 1'b1, 16'h0001, 1'b1, 1'b1, 1'b0}},
      '{1'b1, '{OP_REPORT, 16'h0002, 2'd2, 16'h0000}, 1'b1,
         '{1'b0, 1'b1, 16'h0001, 1'b1, 1'b1, 1'b0}},
      '{1'b1, '{OP_REPORT, 16'h0002, 2'd3, 16'hFFFF}, 1'b1,
         '{1'b0, 1'b1, 16'h0001, 1'b1, 1'b1, 1'b0}},
      '{1'b1, '{OP_MERGE, 16'h0002, STATUS_FAILED, 16'hFFFF}, 1'b1,
         '{1'b1, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0}},
      '{1'b1, '{OP_REPORT, NULL_ID, STATUS_FAILED, 16'h0000}, 1'b1,
         '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0}},
      // fill the remaining slots
      '{1'b1, '{OP_MERGE, 16'h8000, STATUS_PASSED, 16'h1234}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h4001, STATUS_FAILED, 16'h0000}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_REPORT, 16'h2002, STATUS_FAILED, 16'h0000}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h1004, 2'd2, 16'h8001}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_REPORT, 16'h0808, STATUS_FAILED, 16'h5555}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h0410, 2'd3, 16'hAAAA}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h0220, STATUS_PASSED, 16'hFFFE}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_REPORT, 16'h0140, STATUS_FAILED, 16'h0000}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h0081, STATUS_PASSED, 16'h0001}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'hC300, STATUS_FAILED, 16'h00FF}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_REPORT, 16'h3C00, STATUS_FAILED, 16'h0000}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h00F0, STATUS_PASSED, 16'hFF00}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_MERGE, 16'h000F, STATUS_PASSED, 16'h7FFF}, 1'b0, NO_RECORD},
      '{1'b1, '{OP_REPORT, 16'hFFFE, STATUS_FAILED, 16'h0000}, 1'b0, NO_RECORD},
      // no free slot left
      '{1'b1, '{OP_REPORT, 16'h7FFF, STATUS_FAILED, 16'h0000}, 1'b1,
         '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1}},
      '{1'b1, '{OP_MERGE, 16'h0003, STATUS_PASSED, 16'h0005}, 1'b1,
         '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1}}
   };

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   // predicted table contents and ready setting
   logic [15:0] held_id      [SLOTS];
   logic [15:0] held_count   [SLOTS];
   logic        held_failed  [SLOTS];
   logic        held_changed [SLOTS];
   logic        ready_setting;

   pending_type expected_outcomes [$];
   pending_type oldest;
   int          mismatches;

   fault_event_status_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("** fault_event_status_table: FAILED **");
      $finish;
   end

   function automatic int find_held(logic [15:0] id);
      for (int i = 0; i < SLOTS; i++) begin
         if (held_id[i] == id) begin
            return i;
         end
      end
      return SLOTS;
   endfunction

   // applies one request to the predicted table and returns the record it should show
   function automatic rsp_type predict_event_record(req_type it);
      rsp_type rec;
      int      slot;
      rec  = '0;
      slot = SLOTS;
      if (it.event_id != NULL_ID) begin
         slot = find_held(it.event_id);
         if (it.op == OP_REPORT) begin
            if (ready_setting && (it.event_status == STATUS_PASSED ||
                                  it.event_status == STATUS_FAILED)) begin
               if (slot < SLOTS) begin
                  if (held_failed[slot] != it.event_status[0]) begin
                     if (it.event_status == STATUS_FAILED) begin
                        held_count[slot] = held_count[slot] + 16'd1;
                     end
                     held_failed[slot]  = it.event_status[0];
                     held_changed[slot] = 1'b1;
                  end else begin
                     held_changed[slot] = 1'b0;
                  end
                  rec.accepted = 1'b1;
               end else if (it.event_status == STATUS_FAILED) begin
                  slot = find_held(NULL_ID);
                  if (slot < SLOTS) begin
                     held_id[slot]      = it.event_id;
                     held_count[slot]   = 16'd1;
                     held_failed[slot]  = 1'b1;
                     held_changed[slot] = 1'b1;
                     rec.accepted       = 1'b1;
                  end else begin
                     rec.table_full = 1'b1;
                  end
               end
            end
         end else if (slot < SLOTS) begin
            held_count[slot] = held_count[slot] + it.stored_occurrence;
            rec.accepted     = 1'b1;
         end else begin
            slot = find_held(NULL_ID);
            if (slot < SLOTS) begin
               held_id[slot]      = it.event_id;
               held_count[slot]   = it.stored_occurrence;
               held_failed[slot]  = 1'b0;
               held_changed[slot] = 1'b0;
               rec.accepted       = 1'b1;
            end else begin
               rec.table_full = 1'b1;
            end
         end
      end
      if (slot < SLOTS) begin
         rec.found      = 1'b1;
         rec.occurrence = held_count[slot];
         rec.is_failed  = held_failed[slot];
         rec.changed    = held_changed[slot];
      end
      return rec;
   endfunction

   // mostly ids already in the table, some strays, some null and some fully random
   function automatic req_type random_fault_item();
      req_type it;
      int      roll;
      it.op = ($urandom_range(99) < 30) ? OP_MERGE : OP_REPORT;
      roll = $urandom_range(99);
      if (roll < 75) begin
         it.event_id = held_id[$urandom_range(SLOTS - 1)];
      end else if (roll < 80) begin
         it.event_id = NULL_ID;
      end else if (roll < 88) begin
         it.event_id = STRAY_IDS[$urandom_range(3)];
      end else begin
         it.event_id = 16'($urandom);
      end
      roll = $urandom_range(99);
      if (roll < 45) begin
         it.event_status = STATUS_PASSED;
      end else if (roll < 90) begin
         it.event_status = STATUS_FAILED;
      end else begin
         it.event_status = 2'($urandom_range(3, 2));
      end
      roll = $urandom_range(99);
      if (roll < 50) begin
         it.stored_occurrence = 16'($urandom_range(4));
      end else if (roll < 75) begin
         it.stored_occurrence = 16'($urandom);
      end else begin
         it.stored_occurrence = 16'hFFFF - 16'($urandom_range(4));
      end
      return it;
   endfunction

   function automatic int pick_gap(logic steady);
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 40) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(3, 1);
      end
      if (roll < 97) begin
         return $urandom_range(10, 4);
      end
      return $urandom_range(60, 20);
   endfunction

   task automatic note_mismatch(string what, req_type it, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at %0t: op %0b id %h status %0d stored %h", what, $realtime,
                  it.op, it.event_id, it.event_status, it.stored_occurrence);
         $display("   expected acc %b found %b occ %h failed %b changed %b full %b",
                  want.accepted, want.found, want.occurrence, want.is_failed,
                  want.changed, want.table_full);
         $display("   actual   acc %b found %b occ %h failed %b changed %b full %b",
                  got.accepted, got.found, got.occurrence, got.is_failed,
                  got.changed, got.table_full);
      end
   endtask

   // only while idle: no request beat in flight and every result back
   task automatic write_ready(logic value);
      if (start) begin
         start <= 1'b0;
      end
      while (expected_outcomes.size() != 0 || busy) begin
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      ready_setting  = value;
   endtask

   task automatic send_fault_item(req_type it, int gap, logic typed, rsp_type rec);
      pending_type due;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      due.item = it;
      due.rec  = predict_event_record(it);
      if (typed) begin
         due.rec = rec;
      end
      expected_outcomes.push_back(due);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            note_mismatch("result beat with nothing expected", '0, NO_RECORD, rsp_item);
         end else begin
            oldest = expected_outcomes.pop_front();
            if (rsp_item.accepted   !== oldest.rec.accepted   ||
                rsp_item.found      !== oldest.rec.found      ||
                rsp_item.occurrence !== oldest.rec.occurrence ||
                rsp_item.is_failed  !== oldest.rec.is_failed  ||
                rsp_item.changed    !== oldest.rec.changed    ||
                rsp_item.table_full !== oldest.rec.table_full) begin
               note_mismatch("result mismatch", oldest.item, oldest.rec, rsp_item);
            end
         end
      end
   end

   initial begin
      logic steady;
      int   count;
      reset         = 1'b1;
      start         = 1'b0;
      req_item      = '0;
      csr_valid     = 1'b0;
      csr_data      = 1'b0;
      mismatches    = 0;
      ready_setting = 1'b0;
      steady        = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         held_id[i]      = NULL_ID;
         held_count[i]   = 16'd0;
         held_failed[i]  = 1'b0;
         held_changed[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (r == 0 || PLAN[r].ready != ready_setting) begin
            write_ready(PLAN[r].ready);
         end
         send_fault_item(PLAN[r].item, pick_gap(1'b0), PLAN[r].typed, PLAN[r].rec);
      end

      // long ready phases with short not-ready phases between them
      for (int p = 0; p < 5; p++) begin
         write_ready(p % 2 == 0);
         count = (p % 2 == 0) ? 290 : 70;
         for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
               steady = ($urandom_range(3) == 0);
            end
            send_fault_item(random_fault_item(), pick_gap(steady), 1'b0, NO_RECORD);
         end
      end
      start <= 1'b0;

      while (expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SLOTS + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("** fault_event_status_table: PASSED **");
      end else begin
         $display("** fault_event_status_table: FAILED **");
      end
      $finish;
   end

endmodule
